/* hw/rtl/alcs_pkg.sv */
`default_nettype none

package alcs_pkg;

	localparam int COUNT_BITS = 32;

	localparam int SPAN_W  = 32;
	localparam int MASK_W  = 20;
	localparam int PAUSE_W = 16;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	localparam logic [SPAN_W-1:0] SPAN_MAX = (COUNT_BITS >= SPAN_W) ? {SPAN_W{1'b1}} :
		SPAN_W'((64'd1 << COUNT_BITS) - 64'd1);

	localparam logic [PAUSE_W-1:0] PAUSE_MAX = {PAUSE_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_MASK_STEPS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_PAUSE_TICKS = 2'd2;

	localparam logic [MASK_W-1:0]  RST_BOUNCE_MASK_STEPS = 20'd3200;
	localparam logic [PAUSE_W-1:0] RST_PAUSE_TICKS       = 16'd2000;
	localparam logic [PAUSE_W-1:0] RST_FINAL_PAUSE_TICKS = 16'd500;

	typedef struct packed {
		logic mode;
		logic axis;
		logic limit_edge;
	} alcs_req_t;

	typedef struct packed {
		logic               step_valid;
		logic               step_dir;
		logic               step_axis;
		logic [PHASE_W-1:0] phase;
		logic [SPAN_W-1:0]  span;
		logic               stopped;
		logic               done_res;
	} alcs_rsp_t;

	typedef struct packed {
		logic [MASK_W-1:0]  bounce_mask_steps;
		logic [PAUSE_W-1:0] pause_ticks;
		logic [PAUSE_W-1:0] final_pause_ticks;
	} alcs_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/alcs_cfg.sv */
`default_nettype none

module alcs_cfg
	import alcs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output alcs_cfg_t                 cfg
);

	alcs_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce_mask_steps <= RST_BOUNCE_MASK_STEPS;
			cfg_q.pause_ticks       <= RST_PAUSE_TICKS;
			cfg_q.final_pause_ticks <= RST_FINAL_PAUSE_TICKS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOUNCE_MASK_STEPS: cfg_q.bounce_mask_steps <= cfg_data[MASK_W-1:0];
				REG_PAUSE_TICKS:       cfg_q.pause_ticks       <= cfg_data[PAUSE_W-1:0];
				REG_FINAL_PAUSE_TICKS: cfg_q.final_pause_ticks <= cfg_data[PAUSE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/alcs_seq.sv */
`default_nettype none

module alcs_seq
	import alcs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire alcs_cfg_t cfg,
	input  wire logic      fire,
	input  wire alcs_req_t req,
	output alcs_rsp_t      rsp
);

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SEEK    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_PAUSE_A = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MEASURE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAUSE_B = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CENTER  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_FINAL   = 3'd6;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic               axis_q, axis_d;
	logic               cal_q, cal_d;
	logic               mask_q, mask_d;
	logic [SPAN_W-1:0]  span_q [2];
	logic [SPAN_W-1:0]  span_d [2];
	logic [SPAN_W-1:0]  move_q, move_d;
	logic [PAUSE_W-1:0] pcnt_q, pcnt_d;
	logic               stop_q, stop_d;

	logic [SPAN_W-1:0]  cur_span;
	logic [SPAN_W-1:0]  span_inc;
	logic [SPAN_W-1:0]  mask_steps;
	logic [PAUSE_W-1:0] pcnt_inc;
	logic               live;
	logic               step;
	logic               dir;
	logic               done;

	assign cur_span   = span_q[axis_q];
	assign span_inc   = (cur_span != SPAN_MAX) ? cur_span + 1'b1 : cur_span;
	assign mask_steps = {{(SPAN_W-MASK_W){1'b0}}, cfg.bounce_mask_steps};
	assign pcnt_inc   = (pcnt_q != PAUSE_MAX) ? pcnt_q + 1'b1 : pcnt_q;
	assign live       = req.limit_edge & ~mask_q;

	always_comb begin
		phase_d   = phase_q;
		axis_d    = axis_q;
		cal_d     = cal_q;
		mask_d    = mask_q;
		span_d[0] = span_q[0];
		span_d[1] = span_q[1];
		move_d    = move_q;
		pcnt_d    = pcnt_q;
		stop_d    = stop_q;
		step      = 1'b0;
		dir       = 1'b0;
		done      = 1'b0;

		if (req.mode) begin
			axis_d           = req.axis;
			span_d[req.axis] = '0;
			cal_d            = 1'b1;
			mask_d           = 1'b0;
			move_d           = '0;
			pcnt_d           = '0;
			phase_d          = PH_SEEK;
		end else begin
			if (live && !cal_q)
				stop_d = 1'b1;
			case (phase_q)
				PH_SEEK: begin
					if (live) begin
						phase_d = PH_PAUSE_A;
						mask_d  = 1'b1;
						pcnt_d  = '0;
					end else begin
						step = 1'b1;
					end
				end
				PH_PAUSE_A: begin
					pcnt_d = pcnt_inc;
					if (pcnt_inc >= cfg.pause_ticks)
						phase_d = PH_MEASURE;
				end
				PH_MEASURE: begin
					if (live) begin
						phase_d = PH_PAUSE_B;
						pcnt_d  = '0;
					end else begin
						step           = 1'b1;
						dir            = 1'b1;
						span_d[axis_q] = span_inc;
						if (span_inc >= mask_steps)
							mask_d = 1'b0;
					end
				end
				PH_PAUSE_B: begin
					pcnt_d = pcnt_inc;
					if (pcnt_inc >= cfg.pause_ticks) begin
						cal_d   = 1'b0;
						mask_d  = 1'b1;
						move_d  = '0;
						phase_d = PH_CENTER;
					end
				end
				PH_CENTER: begin
					if (move_q < {1'b0, cur_span[SPAN_W-1:1]}) begin
						step = 1'b1;
						if (move_q >= mask_steps)
							mask_d = 1'b0;
						move_d = move_q + 1'b1;
					end else begin
						phase_d = PH_FINAL;
						pcnt_d  = '0;
					end
				end
				PH_FINAL: begin
					pcnt_d = pcnt_inc;
					if (pcnt_inc >= cfg.final_pause_ticks) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
				end
				default: ;
			endcase
		end

		if (stop_d)
			step = 1'b0;
		if (!step)
			dir = 1'b0;

		rsp.step_valid = step;
		rsp.step_dir   = dir;
		rsp.step_axis  = axis_d;
		rsp.phase      = phase_d;
		rsp.span       = span_d[axis_d];
		rsp.stopped    = stop_d;
		rsp.done_res   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			axis_q    <= 1'b0;
			cal_q     <= 1'b0;
			mask_q    <= 1'b0;
			span_q[0] <= '0;
			span_q[1] <= '0;
			move_q    <= '0;
			pcnt_q    <= '0;
			stop_q    <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			axis_q    <= axis_d;
			cal_q     <= cal_d;
			mask_q    <= mask_d;
			span_q[0] <= span_d[0];
			span_q[1] <= span_d[1];
			move_q    <= move_d;
			pcnt_q    <= pcnt_d;
			stop_q    <= stop_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/axis_limit_calibration_sequencer.sv */
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  req (mode, axis, limit_edge)
// rsp      out  rsp_valid / rsp_stall  rsp (step, phase, span, stopped, done)
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request passes through the input register, then the sequencer update into the result register.
// One request per cycle while rsp_stall is low; sequencer state updates once per request.
// rsp_stall holds the result register and, behind it, the input register.
// arst_n clears the sequencer state and both valid flags; config registers return to
// 3200 / 2000 / 500.
`default_nettype none

module axis_limit_calibration_sequencer
	import alcs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire alcs_req_t            req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output alcs_rsp_t                 rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	alcs_cfg_t cfg;
	alcs_req_t req_s1;
	logic      valid_s1;
	alcs_rsp_t rsp_c;
	alcs_rsp_t rsp_q;
	logic      rsp_valid_q;
	logic      adv;

	assign adv       = valid_s1 & ~(rsp_valid_q & rsp_stall);
	assign req_stall = valid_s1 & ~adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	alcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	alcs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (adv),
		.req    (req_s1),
		.rsp    (rsp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			rsp_valid_q <= adv | (rsp_valid_q & rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
		if (adv)
			rsp_q <= rsp_c;
	end

endmodule

`default_nettype wire
